// ----- rtl/core/mp4bs_pkg.sv -----
package mp4bs_pkg;

    // Scan phase of the box walker.
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LARGE   = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_ERROR   = 2'd3
    } phase_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SIZE_ZERO = 3'd1,
        ST_TOO_SMALL = 3'd2,
        ST_TOO_LARGE = 3'd3,
        ST_BAD_TYPE  = 3'd4,
        ST_TRUNCATED = 3'd5
    } status_t;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CHECK_TOP_LEVEL = 2'd0,
        REG_MAX_BOX_SIZE    = 2'd1
    } cfg_reg_t;

    localparam int SIZE_W = 31;
    localparam int TYPE_W = 32;
    localparam int HLEN_W = 5;

    localparam logic [HLEN_W-1:0] HLEN_COMPACT = 5'd8;
    localparam logic [HLEN_W-1:0] HLEN_LARGE   = 5'd16;
    localparam logic [SIZE_W-1:0] MAX_SIZE_RESET = 31'h7FFF_FFFF;

    // Output queue depth: room for the two results one byte can cause, plus slack.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [TYPE_W-1:0] box_type;
        logic [SIZE_W-1:0] total_size;
        logic [HLEN_W-1:0] header_length;
        status_t           status;
        logic              end_report;
        logic              last_in_run;
    } result_t;

    // True for the fifteen legal top-level box codes.
    function automatic logic type_is_legal(input logic [TYPE_W-1:0] code);
        logic hit;
        case (code) inside
            32'h6674_7970, 32'h7064_696E, 32'h626C_6F63, 32'h6D6F_6F76,
            32'h6D6F_6F66, 32'h6D66_7261, 32'h6D64_6174, 32'h6672_6565,
            32'h736B_6970, 32'h6D65_7461, 32'h6D65_636F, 32'h7374_7970,
            32'h7369_6478, 32'h7373_6978, 32'h7072_6674: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// ----- rtl/core/mp4bs_byte_if.sv -----
interface mp4bs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- rtl/core/mp4bs_result_if.sv -----
interface mp4bs_result_if;
    logic                             valid;
    logic                             ready;
    logic [mp4bs_pkg::TYPE_W-1:0]     box_type;
    logic [mp4bs_pkg::SIZE_W-1:0]     total_size;
    logic [mp4bs_pkg::HLEN_W-1:0]     header_length;
    mp4bs_pkg::status_t               status;
    logic                             end_report;
    logic                             last_in_run;

    modport source (
        output valid, output box_type, output total_size, output header_length,
        output status, output end_report, output last_in_run, input ready
    );
    modport sink (
        input valid, input box_type, input total_size, input header_length,
        input status, input end_report, input last_in_run, output ready
    );
endinterface

// ----- rtl/core/mp4bs_cfg_if.sv -----
interface mp4bs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mp4bs_pkg::CFG_INDEX_W-1:0] index;
    logic [mp4bs_pkg::SIZE_W-1:0]      wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

// ----- rtl/core/mp4_box_header_scanner_unit.sv -----
// Box header scanner for an MP4 (ISO base media) byte stream.
// The data channel carries one byte of a buffer per transfer; last_byte marks
// the final byte. For every complete box header the result channel gives one
// header report (type, size, header length, status). On the final byte it
// also gives an end report, clean or truncated, after any header report.
// The cfg channel writes check_top_level (index 0) and max_box_size (index 1);
// it is always ready and should only be used while the scanner is idle.
// Throughput: one byte per cycle while the queue has room. A byte is held in
// an input stage register and its results then enter a four-entry result
// queue, from which the first result of a byte can transfer. A byte that
// causes two results takes two result transfers; the data channel stalls only
// when the queue has fewer than two free entries.
// When the result receiver stalls, results wait in the queue and the data
// channel drops ready once the queue has fewer than two free entries.
// Reset clears the scan state, empties the queue and sets check_top_level to 1
// and max_box_size to 2147483647. After each final byte the scan state returns
// to its reset value; configuration values are kept.
module mp4_box_header_scanner_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    mp4bs_byte_if.sink            data,
    mp4bs_cfg_if.sink             cfg,
    mp4bs_result_if.source        result
);

    // Configuration registers.
    logic                         check_reg;
    logic [mp4bs_pkg::SIZE_W-1:0] max_size_reg;

    // Input stage.
    logic       stage_valid_reg;
    logic [7:0] stage_byte_reg;
    logic       stage_last_reg;

    // Scan state.
    mp4bs_pkg::phase_t            phase_reg, phase_next, phase_mid;
    logic [3:0]                   hbc_reg, hbc_next;
    logic [mp4bs_pkg::SIZE_W-1:0] size_low_reg, size_low_next;
    logic                         size_hi_reg, size_hi_next;
    logic [mp4bs_pkg::TYPE_W-1:0] type_reg, type_next;
    logic [mp4bs_pkg::SIZE_W-1:0] rem_reg, rem_next;

    // Result queue.
    mp4bs_pkg::result_t               fifo_reg [mp4bs_pkg::FIFO_DEPTH];
    logic [mp4bs_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [mp4bs_pkg::FIFO_CNT_W-1:0] count_reg;

    logic advance;
    logic pop;

    // Decode of the current byte against the header fields.
    logic [mp4bs_pkg::SIZE_W-1:0] size_low_shift;
    logic                         size_hi_shift;
    logic [mp4bs_pkg::TYPE_W-1:0] type_shift;
    logic                         at_size_done;
    logic                         at_large_done;
    logic                         size_zero;
    logic                         size_one;
    logic [mp4bs_pkg::SIZE_W-1:0] fin_size;
    logic                         fin_hi;
    logic [mp4bs_pkg::HLEN_W-1:0] fin_hlen;
    logic [mp4bs_pkg::TYPE_W-1:0] fin_type;
    mp4bs_pkg::status_t           fin_status;
    logic [mp4bs_pkg::SIZE_W-1:0] rem_calc;
    logic                         hdr_report;
    mp4bs_pkg::status_t           hdr_status;
    mp4bs_pkg::result_t           hdr_res;
    mp4bs_pkg::result_t           end_res;
    mp4bs_pkg::status_t           end_status;
    logic [1:0]                   push_cnt;

    // Handshakes.
    assign advance    = stage_valid_reg
                        && (count_reg <= mp4bs_pkg::FIFO_CNT_W'(mp4bs_pkg::FIFO_DEPTH - 2));
    assign data.ready = !stage_valid_reg || advance;
    assign cfg.ready  = 1'b1;
    assign pop        = result.valid && result.ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_reg    <= 1'b1;
            max_size_reg <= mp4bs_pkg::MAX_SIZE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                mp4bs_pkg::REG_CHECK_TOP_LEVEL: check_reg    <= cfg.wdata[0];
                mp4bs_pkg::REG_MAX_BOX_SIZE:    max_size_reg <= cfg.wdata;
                default: ;
            endcase
        end
    end

    // Input stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (data.ready)
        begin
            stage_valid_reg <= data.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data.valid && data.ready)
        begin
            stage_byte_reg <= data.data_byte;
            stage_last_reg <= data.last_byte;
        end
    end

    // Shifted views of the size and type with the current byte.
    assign size_low_shift = {size_low_reg[22:0], stage_byte_reg};
    assign size_hi_shift  = size_hi_reg || (size_low_reg[30:23] != 8'd0);
    assign type_shift     = {type_reg[23:0], stage_byte_reg};
    assign at_size_done   = (phase_reg == mp4bs_pkg::PH_HEADER) && (hbc_reg == 4'd7);
    assign at_large_done  = (phase_reg == mp4bs_pkg::PH_LARGE) && (hbc_reg == 4'd15);
    assign size_zero      = !size_hi_reg && (size_low_reg == '0);
    assign size_one       = !size_hi_reg && (size_low_reg == mp4bs_pkg::SIZE_W'(1));

    // Complete header: a compact header checks the stored size with the new
    // type; a large header checks the new size with the stored type.
    assign fin_size = at_large_done ? size_low_shift : size_low_reg;
    assign fin_hi   = at_large_done ? size_hi_shift : size_hi_reg;
    assign fin_hlen = at_large_done ? mp4bs_pkg::HLEN_LARGE : mp4bs_pkg::HLEN_COMPACT;
    assign fin_type = at_large_done ? type_reg : type_shift;
    assign rem_calc = fin_size - mp4bs_pkg::SIZE_W'(fin_hlen);

    // Size checks come before the type check.
    always_comb
    begin
        if (!fin_hi && (fin_size < mp4bs_pkg::SIZE_W'(fin_hlen)))
            fin_status = mp4bs_pkg::ST_TOO_SMALL;
        else if (fin_hi || (fin_size > max_size_reg))
            fin_status = mp4bs_pkg::ST_TOO_LARGE;
        else if (check_reg && !mp4bs_pkg::type_is_legal(fin_type))
            fin_status = mp4bs_pkg::ST_BAD_TYPE;
        else
            fin_status = mp4bs_pkg::ST_OK;
    end

    assign hdr_report = (at_size_done && !size_one) || at_large_done;
    assign hdr_status = (at_size_done && size_zero) ? mp4bs_pkg::ST_SIZE_ZERO : fin_status;

    // Next phase.
    always_comb
    begin
        phase_mid = phase_reg;
        unique case (phase_reg)
            mp4bs_pkg::PH_HEADER:
            begin
                if (hbc_reg == 4'd7)
                begin
                    if (size_zero || (!size_one && fin_status != mp4bs_pkg::ST_OK))
                        phase_mid = mp4bs_pkg::PH_ERROR;
                    else if (size_one)
                        phase_mid = mp4bs_pkg::PH_LARGE;
                    else if (rem_calc == '0)
                        phase_mid = mp4bs_pkg::PH_HEADER;
                    else
                        phase_mid = mp4bs_pkg::PH_PAYLOAD;
                end
            end
            mp4bs_pkg::PH_LARGE:
            begin
                if (hbc_reg == 4'd15)
                begin
                    if (fin_status != mp4bs_pkg::ST_OK)
                        phase_mid = mp4bs_pkg::PH_ERROR;
                    else if (rem_calc == '0)
                        phase_mid = mp4bs_pkg::PH_HEADER;
                    else
                        phase_mid = mp4bs_pkg::PH_PAYLOAD;
                end
            end
            mp4bs_pkg::PH_PAYLOAD:
            begin
                if (rem_reg <= mp4bs_pkg::SIZE_W'(1))
                    phase_mid = mp4bs_pkg::PH_HEADER;
            end
            mp4bs_pkg::PH_ERROR: phase_mid = mp4bs_pkg::PH_ERROR;
            default: phase_mid = phase_reg;
        endcase

        if (!advance)
            phase_next = phase_reg;
        else if (stage_last_reg)
            phase_next = mp4bs_pkg::PH_HEADER;
        else
            phase_next = phase_mid;
    end

    // Counters, shift registers and results.
    always_comb
    begin
        hbc_next      = hbc_reg;
        size_low_next = size_low_reg;
        size_hi_next  = size_hi_reg;
        type_next     = type_reg;
        rem_next      = rem_reg;

        unique case (phase_reg)
            mp4bs_pkg::PH_HEADER:
            begin
                if (hbc_reg < 4'd4)
                begin
                    size_low_next = size_low_shift;
                    size_hi_next  = size_hi_shift;
                end
                else
                begin
                    type_next = type_shift;
                end
                if (hbc_reg == 4'd7)
                begin
                    hbc_next      = size_one ? 4'd8 : 4'd0;
                    size_low_next = '0;
                    size_hi_next  = 1'b0;
                    if (!size_zero && !size_one && fin_status == mp4bs_pkg::ST_OK)
                        rem_next = rem_calc;
                end
                else
                begin
                    hbc_next = hbc_reg + 4'd1;
                end
            end
            mp4bs_pkg::PH_LARGE:
            begin
                if (hbc_reg == 4'd15)
                begin
                    hbc_next      = 4'd0;
                    size_low_next = '0;
                    size_hi_next  = 1'b0;
                    if (fin_status == mp4bs_pkg::ST_OK)
                        rem_next = rem_calc;
                end
                else
                begin
                    hbc_next      = hbc_reg + 4'd1;
                    size_low_next = size_low_shift;
                    size_hi_next  = size_hi_shift;
                end
            end
            mp4bs_pkg::PH_PAYLOAD:
            begin
                if (rem_reg != '0)
                    rem_next = rem_reg - mp4bs_pkg::SIZE_W'(1);
            end
            mp4bs_pkg::PH_ERROR: ;
            default: ;
        endcase

        // Truncated when the final byte leaves a header or payload open.
        if ((phase_mid == mp4bs_pkg::PH_LARGE) || (phase_mid == mp4bs_pkg::PH_PAYLOAD)
            || ((phase_mid == mp4bs_pkg::PH_HEADER) && (hbc_next != 4'd0)))
            end_status = mp4bs_pkg::ST_TRUNCATED;
        else
            end_status = mp4bs_pkg::ST_OK;

        if (stage_last_reg)
        begin
            hbc_next      = 4'd0;
            size_low_next = '0;
            size_hi_next  = 1'b0;
            rem_next      = '0;
        end

        hdr_res.box_type      = fin_type;
        hdr_res.total_size    = (hdr_status == mp4bs_pkg::ST_OK) ? fin_size : '0;
        hdr_res.header_length = fin_hlen;
        hdr_res.status        = hdr_status;
        hdr_res.end_report    = 1'b0;
        hdr_res.last_in_run   = !stage_last_reg;

        end_res.box_type      = '0;
        end_res.total_size    = '0;
        end_res.header_length = '0;
        end_res.status        = end_status;
        end_res.end_report    = 1'b1;
        end_res.last_in_run   = 1'b1;

        push_cnt = advance ? ({1'b0, hdr_report} + {1'b0, stage_last_reg}) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= mp4bs_pkg::PH_HEADER;
            hbc_reg      <= 4'd0;
            size_low_reg <= '0;
            size_hi_reg  <= 1'b0;
            rem_reg      <= '0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            hbc_reg      <= hbc_next;
            size_low_reg <= size_low_next;
            size_hi_reg  <= size_hi_next;
            rem_reg      <= rem_next;
        end
    end

    // The type is always fully refilled before it is reported.
    always_ff @(posedge clk)
    begin
        if (advance)
            type_reg <= type_next;
    end

    // Result queue: up to two entries written per cycle, one read.
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            fifo_reg[wr_ptr_reg] <= hdr_report ? hdr_res : end_res;
        if (push_cnt == 2'd2)
            fifo_reg[wr_ptr_reg + mp4bs_pkg::FIFO_PTR_W'(1)] <= end_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + mp4bs_pkg::FIFO_PTR_W'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + mp4bs_pkg::FIFO_PTR_W'(pop);
            count_reg  <= count_reg + mp4bs_pkg::FIFO_CNT_W'(push_cnt)
                          - mp4bs_pkg::FIFO_CNT_W'(pop);
        end
    end

    // Result channel.
    assign result.valid         = (count_reg != '0);
    assign result.box_type      = fifo_reg[rd_ptr_reg].box_type;
    assign result.total_size    = fifo_reg[rd_ptr_reg].total_size;
    assign result.header_length = fifo_reg[rd_ptr_reg].header_length;
    assign result.status        = fifo_reg[rd_ptr_reg].status;
    assign result.end_report    = fifo_reg[rd_ptr_reg].end_report;
    assign result.last_in_run   = fifo_reg[rd_ptr_reg].last_in_run;

    // The queue never overflows.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mp4bs_pkg::FIFO_CNT_W'(mp4bs_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // No header report is produced while skipping after an error.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == mp4bs_pkg::PH_ERROR) |-> !hdr_report)
        else $error("header report in error phase");

    // The final byte always leaves the scanner at the start of a new buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stage_last_reg)
        |=> (phase_reg == mp4bs_pkg::PH_HEADER && hbc_reg == 4'd0 && rem_reg == '0))
        else $error("scan state not cleared after final byte");

    // Payload phase always has bytes left to skip.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == mp4bs_pkg::PH_PAYLOAD) |-> (rem_reg != '0))
        else $error("payload phase with nothing remaining");

    // An end report always closes the run of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.end_report) |-> result.last_in_run)
        else $error("end report not marked last in run");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BYTES  = 135;
    localparam int NUM_SETTINGS = 6;
    localparam int NUM_DIRECTED = 43;
    localparam int NUM_FIXED    = 8;

    // The fifteen box codes allowed at the top level of a file.
    localparam logic [31:0] TOP_CODES [15] = '{
        32'h6674_7970, 32'h7064_696E, 32'h626C_6F63, 32'h6D6F_6F76, 32'h6D6F_6F66,
        32'h6D66_7261, 32'h6D64_6174, 32'h6672_6565, 32'h736B_6970, 32'h6D65_7461,
        32'h6D65_636F, 32'h7374_7970, 32'h7369_6478, 32'h7373_6978, 32'h7072_6674
    };

    // Register settings for the random phases; the last one runs without idling.
    localparam logic SET_CHECK [NUM_SETTINGS] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    localparam logic [30:0] SET_LIMIT [NUM_SETTINGS] = '{
        31'h7FFF_FFFF, 31'd40, 31'd16, 31'd0, 31'd24, 31'h7FFF_FFFF
    };

    // Directed bytes: bit 8 is last_byte, bits 7:0 the data byte.
    localparam logic [8:0] DIRECTED_BYTES [NUM_DIRECTED] = '{
        // Box of exactly header size, then a box of size zero and a closing byte.
        9'h000, 9'h000, 9'h000, 9'h008, 9'h066, 9'h072, 9'h065, 9'h065,
        9'h000, 9'h000, 9'h000, 9'h000, 9'h06D, 9'h06F, 9'h06F, 9'h076,
        9'h1FF,
        // Largest size with an unknown type, ending on the header's last byte.
        9'h07F, 9'h0FF, 9'h0FF, 9'h0FF, 9'h061, 9'h062, 9'h063, 9'h164,
        // Size below header length wins over an unknown type.
        9'h000, 9'h000, 9'h000, 9'h007, 9'h07A, 9'h07A, 9'h07A, 9'h07A,
        9'h15A,
        // Large-size header cut short.
        9'h000, 9'h000, 9'h000, 9'h001, 9'h06D, 9'h064, 9'h061, 9'h074,
        9'h100
    };

    typedef struct packed {
        logic [7:0]         row;
        mp4bs_pkg::result_t want;
    } fixed_result_t;

    // Results that can be read straight off the directed bytes.
    localparam fixed_result_t FIXED_RESULTS [NUM_FIXED] = '{
        '{8'd7,  '{32'h6672_6565, 31'd8, mp4bs_pkg::HLEN_COMPACT, mp4bs_pkg::ST_OK,
                   1'b0, 1'b1}},
        '{8'd15, '{32'h6D6F_6F76, 31'd0, mp4bs_pkg::HLEN_COMPACT, mp4bs_pkg::ST_SIZE_ZERO,
                   1'b0, 1'b1}},
        '{8'd16, '{32'd0, 31'd0, 5'd0, mp4bs_pkg::ST_OK, 1'b1, 1'b1}},
        '{8'd24, '{32'h6162_6364, 31'd0, mp4bs_pkg::HLEN_COMPACT, mp4bs_pkg::ST_BAD_TYPE,
                   1'b0, 1'b0}},
        '{8'd24, '{32'd0, 31'd0, 5'd0, mp4bs_pkg::ST_OK, 1'b1, 1'b1}},
        '{8'd32, '{32'h7A7A_7A7A, 31'd0, mp4bs_pkg::HLEN_COMPACT, mp4bs_pkg::ST_TOO_SMALL,
                   1'b0, 1'b1}},
        '{8'd33, '{32'd0, 31'd0, 5'd0, mp4bs_pkg::ST_OK, 1'b1, 1'b1}},
        '{8'd42, '{32'd0, 31'd0, 5'd0, mp4bs_pkg::ST_TRUNCATED, 1'b1, 1'b1}}
    };

    logic clk;
    logic rst_n;

    mp4bs_byte_if   data_ch ();
    mp4bs_cfg_if    cfg_ch ();
    mp4bs_result_if res_ch ();

    mp4_box_header_scanner_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .data   (data_ch),
        .cfg    (cfg_ch),
        .result (res_ch)
    );

    // Scanner state as the testbench sees it, and its copy of the registers.
    mp4bs_pkg::phase_t scan_phase;
    logic [3:0]        hdr_count;
    logic [63:0]       size_acc;
    logic [31:0]       type_acc;
    logic [30:0]       payload_left;
    logic              check_types;
    logic [30:0]       size_limit;

    mp4bs_pkg::result_t expected_reports[$];
    logic [7:0]         box_bytes[$];

    int mismatches;
    int reports_checked;
    int bytes_sent;
    int buffers_sent;
    int cycles;
    int status_seen [6];
    bit quiet;
    bit hold_request;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up if the run hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, expected_reports.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic is_top_code(input logic [31:0] code);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < 15; i++)
            if (TOP_CODES[i] == code)
                hit = 1'b1;
        return hit;
    endfunction

    function automatic void push_report(input logic [31:0] code, input logic [30:0] sz,
                                        input logic [4:0] hlen,
                                        input mp4bs_pkg::status_t st,
                                        input logic is_end);
        mp4bs_pkg::result_t r;
        r.box_type      = code;
        r.total_size    = sz;
        r.header_length = hlen;
        r.status        = st;
        r.end_report    = is_end;
        r.last_in_run   = 1'b0;
        expected_reports.push_back(r);
    endfunction

    function automatic void clear_scan();
        scan_phase   = mp4bs_pkg::PH_HEADER;
        hdr_count    = '0;
        size_acc     = '0;
        type_acc     = '0;
        payload_left = '0;
    endfunction

    // Size checks come first, then the type check; a good box moves on to its payload.
    function automatic void close_header(input logic [63:0] sz, input logic [4:0] hlen);
        mp4bs_pkg::status_t st;
        st = mp4bs_pkg::ST_OK;
        if (sz < 64'(hlen))
            st = mp4bs_pkg::ST_TOO_SMALL;
        else if (sz > {33'd0, size_limit})
            st = mp4bs_pkg::ST_TOO_LARGE;
        else if (check_types && !is_top_code(type_acc))
            st = mp4bs_pkg::ST_BAD_TYPE;
        if (st != mp4bs_pkg::ST_OK)
        begin
            push_report(type_acc, 31'd0, hlen, st, 1'b0);
            scan_phase = mp4bs_pkg::PH_ERROR;
        end
        else
        begin
            push_report(type_acc, sz[30:0], hlen, mp4bs_pkg::ST_OK, 1'b0);
            payload_left = sz[30:0] - 31'(hlen);
            scan_phase = (payload_left != 0) ? mp4bs_pkg::PH_PAYLOAD : mp4bs_pkg::PH_HEADER;
        end
        hdr_count = '0;
        size_acc  = '0;
    endfunction

    // Advance the scan by one byte; returns how many reports it adds.
    function automatic int scan_byte(input logic [7:0] value, input logic is_last);
        int                 start_count;
        logic               cut_short;
        mp4bs_pkg::result_t r;
        start_count = expected_reports.size();
        case (scan_phase)
            mp4bs_pkg::PH_HEADER:
            begin
                if (hdr_count < 4)
                    size_acc = {32'd0, size_acc[23:0], value};
                else
                    type_acc = {type_acc[23:0], value};
                if (hdr_count == 7)
                begin
                    if (size_acc == 0)
                    begin
                        push_report(type_acc, 31'd0, mp4bs_pkg::HLEN_COMPACT,
                                    mp4bs_pkg::ST_SIZE_ZERO, 1'b0);
                        scan_phase = mp4bs_pkg::PH_ERROR;
                        hdr_count  = '0;
                        size_acc   = '0;
                    end
                    else if (size_acc == 1)
                    begin
                        scan_phase = mp4bs_pkg::PH_LARGE;
                        hdr_count  = 4'd8;
                        size_acc   = '0;
                    end
                    else
                    begin
                        close_header(size_acc, mp4bs_pkg::HLEN_COMPACT);
                    end
                end
                else
                begin
                    hdr_count = hdr_count + 4'd1;
                end
            end
            mp4bs_pkg::PH_LARGE:
            begin
                size_acc = {size_acc[55:0], value};
                if (hdr_count >= 15)
                    close_header(size_acc, mp4bs_pkg::HLEN_LARGE);
                else
                    hdr_count = hdr_count + 4'd1;
            end
            mp4bs_pkg::PH_PAYLOAD:
            begin
                if (payload_left > 0)
                    payload_left = payload_left - 31'd1;
                if (payload_left == 0)
                    scan_phase = mp4bs_pkg::PH_HEADER;
            end
            default: ;
        endcase

        // The final byte of a buffer always closes with an end report.
        if (is_last)
        begin
            cut_short = (scan_phase == mp4bs_pkg::PH_LARGE)
                        || (scan_phase == mp4bs_pkg::PH_PAYLOAD)
                        || (scan_phase == mp4bs_pkg::PH_HEADER && hdr_count != 0);
            push_report(32'd0, 31'd0, 5'd0,
                        cut_short ? mp4bs_pkg::ST_TRUNCATED : mp4bs_pkg::ST_OK, 1'b1);
            clear_scan();
        end

        if (expected_reports.size() > start_count)
        begin
            r = expected_reports.pop_back();
            r.last_in_run = 1'b1;
            expected_reports.push_back(r);
        end
        return expected_reports.size() - start_count;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] seen,
                                   input logic [63:0] wanted);
        mismatches++;
        $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h",
                 $time, what, seen, wanted);
    endtask

    // Compare every result transfer with the oldest expected report.
    always @(posedge clk)
    begin : result_monitor
        mp4bs_pkg::result_t got;
        mp4bs_pkg::result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.box_type      = res_ch.box_type;
            got.total_size    = res_ch.total_size;
            got.header_length = res_ch.header_length;
            got.status        = res_ch.status;
            got.end_report    = res_ch.end_report;
            got.last_in_run   = res_ch.last_in_run;
            if (got.status <= mp4bs_pkg::ST_TRUNCATED)
                status_seen[int'(got.status)]++;
            if (expected_reports.size() == 0)
            begin
                report_mismatch("result with nothing expected", 64'(got.box_type), 64'd0);
            end
            else
            begin
                want = expected_reports.pop_front();
                reports_checked++;
                if (got.box_type != want.box_type)
                    report_mismatch("box_type", 64'(got.box_type), 64'(want.box_type));
                if (got.total_size != want.total_size)
                    report_mismatch("total_size", 64'(got.total_size),
                                    64'(want.total_size));
                if (got.header_length != want.header_length)
                    report_mismatch("header_length", 64'(got.header_length),
                                    64'(want.header_length));
                if (got.status != want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.end_report != want.end_report)
                    report_mismatch("end_report", 64'(got.end_report), 64'(want.end_report));
                if (got.last_in_run != want.last_in_run)
                    report_mismatch("last_in_run", 64'(got.last_in_run),
                                    64'(want.last_in_run));
            end
        end
    end

    // Result receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin : result_receiver
        int held;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                res_ch.ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    held++;
                end
                res_ch.ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one byte, wait for its transfer, then predict what it causes.
    task automatic offer_byte(input logic [7:0] value, input logic is_last,
                              output int produced);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            data_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        data_ch.valid     <= 1'b1;
        data_ch.data_byte <= value;
        data_ch.last_byte <= is_last;
        do @(posedge clk); while (!data_ch.ready);
        produced = scan_byte(value, is_last);
        bytes_sent++;
        if (is_last)
            buffers_sent++;
    endtask

    // Stop offering bytes and let every outstanding report arrive.
    task automatic drain_reports();
        data_ch.valid <= 1'b0;
        wait (expected_reports.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Both registers in two back-to-back transfers; upper bits of the flag are junk.
    task automatic write_settings(input logic check_on, input logic [30:0] limit);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= mp4bs_pkg::REG_CHECK_TOP_LEVEL;
        cfg_ch.wdata <= {30'($urandom()), check_on};
        do @(posedge clk); while (!cfg_ch.ready);
        check_types = check_on;
        cfg_ch.index <= mp4bs_pkg::REG_MAX_BOX_SIZE;
        cfg_ch.wdata <= limit;
        do @(posedge clk); while (!cfg_ch.ready);
        size_limit = limit;
        cfg_ch.valid <= 1'b0;
    endtask

    // Append one box: mostly well formed, some with each kind of header error.
    function automatic void append_box();
        int          kind;
        int          body;
        int          hlen;
        logic [31:0] code;
        logic [63:0] sz;
        logic        large_hdr;
        kind      = $urandom_range(0, 99);
        code      = TOP_CODES[$urandom_range(0, 14)];
        large_hdr = ($urandom_range(0, 3) == 0);
        sz        = large_hdr ? 64'($urandom_range(16, 48)) : 64'($urandom_range(8, 40));
        if (kind < 8)
        begin
            large_hdr = 1'b0;
            sz = 64'd0;
        end
        else if (kind < 16)
        begin
            sz = large_hdr ? 64'($urandom_range(0, 15)) : 64'($urandom_range(2, 7));
        end
        else if (kind < 22)
        begin
            sz = large_hdr ? ({$urandom(), $urandom()} | 64'h8000_0000)
                           : {32'd0, $urandom() | 32'h8000_0000};
        end
        else if (kind < 30)
        begin
            code = $urandom();
        end
        else if (kind < 36 && size_limit >= 8 && size_limit <= 64)
        begin
            // Right at the size limit, or one past it.
            sz = 64'(size_limit) + 64'($urandom_range(0, 1));
            large_hdr = large_hdr && (sz >= 16);
        end

        if (large_hdr)
        begin
            for (int i = 3; i >= 0; i--)
                box_bytes.push_back((i == 0) ? 8'h01 : 8'h00);
            for (int i = 3; i >= 0; i--)
                box_bytes.push_back(code[i*8 +: 8]);
            for (int i = 7; i >= 0; i--)
                box_bytes.push_back(sz[i*8 +: 8]);
        end
        else
        begin
            for (int i = 3; i >= 0; i--)
                box_bytes.push_back(sz[i*8 +: 8]);
            for (int i = 3; i >= 0; i--)
                box_bytes.push_back(code[i*8 +: 8]);
        end

        // Payload for a usable size; a few stray bytes after an error.
        hlen = large_hdr ? 16 : 8;
        body = (sz >= 64'(hlen) && sz <= 64) ? int'(sz) - hlen : $urandom_range(0, 6);
        for (int i = 0; i < body; i++)
            box_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // One buffer: a few boxes, sometimes cut short, sometimes pure noise.
    function automatic void build_buffer();
        int         count;
        int         cut;
        logic [7:0] dropped;
        box_bytes.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            count = $urandom_range(1, 12);
            for (int i = 0; i < count; i++)
                box_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            count = $urandom_range(1, 4);
            for (int i = 0; i < count; i++)
                append_box();
            if ($urandom_range(0, 6) == 0)
            begin
                cut = $urandom_range(1, box_bytes.size());
                while (box_bytes.size() > cut)
                    dropped = box_bytes.pop_back();
            end
        end
    endfunction

    // Main stimulus.
    initial
    begin : stimulus
        int                 produced;
        int                 start_bytes;
        logic               typed_row;
        bit                 held;
        bit                 paused;
        mp4bs_pkg::result_t dropped;

        rst_n              <= 1'b0;
        data_ch.valid      <= 1'b0;
        data_ch.data_byte  <= 8'h00;
        data_ch.last_byte  <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= mp4bs_pkg::REG_CHECK_TOP_LEVEL;
        cfg_ch.wdata       <= '0;
        quiet              = 1'b0;
        hold_request       = 1'b0;
        held               = 1'b0;
        paused             = 1'b0;
        check_types        = 1'b1;
        size_limit         = mp4bs_pkg::MAX_SIZE_RESET;
        clear_scan();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under the reset register values.
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            offer_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8], produced);
            typed_row = 1'b0;
            for (int k = 0; k < NUM_FIXED; k++)
            begin
                if (FIXED_RESULTS[k].row == 8'(i))
                begin
                    if (!typed_row)
                        repeat (produced) dropped = expected_reports.pop_back();
                    typed_row = 1'b1;
                    expected_reports.push_back(FIXED_RESULTS[k].want);
                end
            end
        end

        // Random buffers under each register setting in turn.
        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            drain_reports();
            quiet = (s == NUM_SETTINGS - 1);
            write_settings(SET_CHECK[s], SET_LIMIT[s]);
            start_bytes = bytes_sent;
            while (bytes_sent - start_bytes < PHASE_BYTES)
            begin
                build_buffer();
                for (int i = 0; i < box_bytes.size(); i++)
                    offer_byte(box_bytes[i], i == box_bytes.size() - 1, produced);
                // Long receiver hold-off while bytes keep coming.
                if (s == 1 && !held)
                begin
                    hold_request = 1'b1;
                    held = 1'b1;
                end
                // Sender pause until the result side has caught up.
                if (s == 2 && !paused && bytes_sent - start_bytes > 80)
                begin
                    drain_reports();
                    paused = 1'b1;
                end
            end
        end

        drain_reports();
        $display("Run covered %0d bytes in %0d buffers over %0d register settings.",
                 bytes_sent, buffers_sent, NUM_SETTINGS);
        $display("Checked %0d results: ok %0d, size zero %0d, too small %0d,",
                 reports_checked, status_seen[0], status_seen[1], status_seen[2]);
        $display("  too large %0d, bad type %0d, truncated %0d.",
                 status_seen[3], status_seen[4], status_seen[5]);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
